// File: rtl/core/qvr_pkg.sv
// Package for the quaternion vector rotate block: beat payload types and
// internal datapath widths. No dependencies.
package qvr_pkg;

    // Input beat: quaternion in Q1.15, vector in Q16.16.
    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_rot_in;

    // Output beat: rotated vector in Q16.16, saturated, plus clip flag.
    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               clipped;
    } t_rot_out;

    localparam int W_Q    = 16;  // quaternion component
    localparam int W_V    = 32;  // vector component
    localparam int W_PROD = 48;  // u*v product
    localparam int W_DIFF = 49;  // u*v cross difference
    localparam int W_C    = 35;  // rounded cross product, 16 fraction bits
    localparam int W_T    = 51;  // w*c and u*c products and their sums
    localparam int W_D    = 38;  // rounded 2*t, Q16.16
    localparam int W_SUM  = 39;  // v + d before clamp

    localparam int SH_C = 15;    // 31 -> 16 fraction bits
    localparam int SH_D = 14;    // 31 -> 16 fraction bits, times two

    localparam logic signed [W_DIFF-1:0] RND_C = W_DIFF'(2 ** (SH_C - 1));
    localparam logic signed [W_T-1:0]    RND_D = W_T'(2 ** (SH_D - 1));

    localparam int NUM_STG = 5;

endpackage

// File: rtl/core/quaternion_vector_rotate.sv
// Quaternion vector rotate, five-stage pipeline: v' = v + 2*(w*(u x v) + u x (u x v)).
// Depends on qvr_pkg (beat types, datapath widths, rounding constants).
//
// Usage:
//   Input channel  (i_in_valid / o_in_ready / i_in_data): one beat carries the
//   quaternion (w, x, y, z) in Q1.15 and the vector (x, y, z) in Q16.16.
//   Output channel (o_out_valid / i_out_ready / o_out_data): one beat per input
//   beat, in order, with the rotated vector in Q16.16, each component clamped
//   to 32 bits, and clipped set when any component was clamped.
//   o_out_valid rises once the beat has passed the five register stages, the first
//   loaded at the accepting edge, when the receiver does not stall. Throughput is
//   one beat per cycle while i_out_ready stays high; the multiplier stages
//   (six 16x32 products in stage 1, nine 16x35 products in stage 3) set the
//   stage depth, each product being registered before any add that uses it.
//   Each stage holds its own valid bit and loads when it is empty or when the
//   stage after it moves on, so bubbles are squeezed out and the input stays
//   ready while a finished result waits at the output.
//   When the receiver stalls, the output register holds its beat and stages
//   fill up behind it; o_in_ready drops only once all five stages hold beats.
//   Synchronous active-low reset clears the valid bits; the pipeline is empty
//   and ready to accept in the first cycle after reset.

module quaternion_vector_rotate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  qvr_pkg::t_rot_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output qvr_pkg::t_rot_out o_out_data
);
    import qvr_pkg::*;

    // stage enables and valid bits, index 0 = first stage
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] stg_en;

    // input unpacked into component arrays
    logic signed [W_Q-1:0] in_u [3];
    logic signed [W_V-1:0] in_v [3];

    // stage 1: cross product terms of u x v
    logic signed [W_PROD-1:0] r_s1_pa [3];
    logic signed [W_PROD-1:0] r_s1_pb [3];
    logic signed [W_PROD-1:0] n_s1_pa [3];
    logic signed [W_PROD-1:0] n_s1_pb [3];
    logic signed [W_Q-1:0]    r_s1_w;
    logic signed [W_Q-1:0]    r_s1_u [3];
    logic signed [W_V-1:0]    r_s1_v [3];

    // stage 2: c = u x v, rounded to 16 fraction bits
    logic signed [W_DIFF-1:0] s2_diff [3];
    logic signed [W_DIFF-1:0] s2_shr  [3];
    logic signed [W_C-1:0]    r_s2_c [3];
    logic signed [W_C-1:0]    n_s2_c [3];
    logic signed [W_Q-1:0]    r_s2_w;
    logic signed [W_Q-1:0]    r_s2_u [3];
    logic signed [W_V-1:0]    r_s2_v [3];

    // stage 3: w*c and the cross terms of u x c
    logic signed [W_T-1:0] r_s3_pw [3];
    logic signed [W_T-1:0] r_s3_pa [3];
    logic signed [W_T-1:0] r_s3_pb [3];
    logic signed [W_T-1:0] n_s3_pw [3];
    logic signed [W_T-1:0] n_s3_pa [3];
    logic signed [W_T-1:0] n_s3_pb [3];
    logic signed [W_V-1:0] r_s3_v [3];

    // stage 4: d = 2*t rounded to Q16.16
    logic signed [W_T-1:0] s4_t   [3];
    logic signed [W_T-1:0] s4_shr [3];
    logic signed [W_D-1:0] r_s4_d [3];
    logic signed [W_D-1:0] n_s4_d [3];
    logic signed [W_V-1:0] r_s4_v [3];

    // stage 5: v + d, clamp, output register
    logic signed [W_SUM-1:0] s5_sum [3];
    logic signed [W_V-1:0]   s5_rot [3];
    logic [2:0]              s5_clip;
    t_rot_out                r_out;
    t_rot_out                n_out;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when its successor loads.
    // ------------------------------------------------------------------
    always_comb begin
        stg_en[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = stg_en[0];
    assign o_out_valid = r_vld[NUM_STG-1];
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Stage 1: products of u x v
    // ------------------------------------------------------------------
    always_comb begin
        in_u[0] = i_in_data.quat_x;
        in_u[1] = i_in_data.quat_y;
        in_u[2] = i_in_data.quat_z;
        in_v[0] = i_in_data.vec_x;
        in_v[1] = i_in_data.vec_y;
        in_v[2] = i_in_data.vec_z;

        n_s1_pa[0] = W_PROD'(in_u[1]) * W_PROD'(in_v[2]);
        n_s1_pb[0] = W_PROD'(in_u[2]) * W_PROD'(in_v[1]);
        n_s1_pa[1] = W_PROD'(in_u[2]) * W_PROD'(in_v[0]);
        n_s1_pb[1] = W_PROD'(in_u[0]) * W_PROD'(in_v[2]);
        n_s1_pa[2] = W_PROD'(in_u[0]) * W_PROD'(in_v[1]);
        n_s1_pb[2] = W_PROD'(in_u[1]) * W_PROD'(in_v[0]);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_w <= i_in_data.quat_w;
            for (int i = 0; i < 3; i++) begin
                r_s1_pa[i] <= n_s1_pa[i];
                r_s1_pb[i] <= n_s1_pb[i];
                r_s1_u[i]  <= in_u[i];
                r_s1_v[i]  <= in_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: c = round_half_up((pa - pb) / 2^15)
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_diff[i] = W_DIFF'(r_s1_pa[i]) - W_DIFF'(r_s1_pb[i]) + RND_C;
            s2_shr[i]  = s2_diff[i] >>> SH_C;
            n_s2_c[i]  = s2_shr[i][W_C-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_w <= r_s1_w;
            for (int i = 0; i < 3; i++) begin
                r_s2_c[i] <= n_s2_c[i];
                r_s2_u[i] <= r_s1_u[i];
                r_s2_v[i] <= r_s1_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: w*c and products of u x c
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s3_pw[i] = W_T'(r_s2_w) * W_T'(r_s2_c[i]);
        end
        n_s3_pa[0] = W_T'(r_s2_u[1]) * W_T'(r_s2_c[2]);
        n_s3_pb[0] = W_T'(r_s2_u[2]) * W_T'(r_s2_c[1]);
        n_s3_pa[1] = W_T'(r_s2_u[2]) * W_T'(r_s2_c[0]);
        n_s3_pb[1] = W_T'(r_s2_u[0]) * W_T'(r_s2_c[2]);
        n_s3_pa[2] = W_T'(r_s2_u[0]) * W_T'(r_s2_c[1]);
        n_s3_pb[2] = W_T'(r_s2_u[1]) * W_T'(r_s2_c[0]);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_pw[i] <= n_s3_pw[i];
                r_s3_pa[i] <= n_s3_pa[i];
                r_s3_pb[i] <= n_s3_pb[i];
                r_s3_v[i]  <= r_s2_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: t = w*c + u x c, d = round_half_up(t / 2^14)
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_t[i]   = r_s3_pw[i] + r_s3_pa[i] - r_s3_pb[i] + RND_D;
            s4_shr[i] = s4_t[i] >>> SH_D;
            n_s4_d[i] = s4_shr[i][W_D-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_d[i] <= n_s4_d[i];
                r_s4_v[i] <= r_s3_v[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: v + d, clamp to 32 bits
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s5_sum[i] = W_SUM'(r_s4_v[i]) + W_SUM'(r_s4_d[i]);
            // in range when all bits above the sign of the 32-bit result agree
            if (!s5_sum[i][W_SUM-1] && (|s5_sum[i][W_SUM-2:W_V-1])) begin
                s5_rot[i]  = {1'b0, {(W_V-1){1'b1}}};
                s5_clip[i] = 1'b1;
            end else if (s5_sum[i][W_SUM-1] && !(&s5_sum[i][W_SUM-2:W_V-1])) begin
                s5_rot[i]  = {1'b1, {(W_V-1){1'b0}}};
                s5_clip[i] = 1'b1;
            end else begin
                s5_rot[i]  = s5_sum[i][W_V-1:0];
                s5_clip[i] = 1'b0;
            end
        end
        n_out.rot_x   = s5_rot[0];
        n_out.rot_y   = s5_rot[1];
        n_out.rot_z   = s5_rot[2];
        n_out.clipped = |s5_clip;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_out <= n_out;
        end
    end

endmodule

// File: bench/testbench.sv
// Self-checking bench for quaternion_vector_rotate: random and directed rotations
// checked against an in-bench fixed-point predictor. Depends on qvr_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import qvr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int DRAIN_CYCLES  = 4 * NUM_STG;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int REPORT_LIMIT  = 60;

    // Q1.15 quaternion codes and Q16.16 vector codes used by the directed beats.
    localparam logic signed [15:0] Q_ONE  = 16'sd32767;
    localparam logic signed [15:0] Q_NEG1 = -16'sd32768;
    localparam logic signed [15:0] Q_HALF_SQRT2 = 16'sd23170;  // cos(45 deg)
    localparam logic signed [31:0] V_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] V_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] V_ONE  = 32'sh0001_0000;

    // Receiver behavior, switched to a random mode after a random hold.
    typedef enum logic [1:0] {
        RX_OPEN,      // always ready
        RX_LIGHT,     // ready with probability 3/4, random
        RX_HEAVY,     // ready with probability 1/4, random
        RX_PERIODIC   // fixed on/off pattern
    } rx_mode_e;

    // ------------------------------------------------------------------
    // Scoreboard: predicts each accepted beat, checks outputs in order.
    // ------------------------------------------------------------------
    class rotate_scoreboard;
        t_rot_out rotated_q[$];
        int       errors;
        int       reports;

        // Round half up: add half an LSB of the target, then floor-shift.
        function longint round_half_up(longint x, int s);
            return (x + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        // v' = v + 2*(w*(u x v) + u x (u x v)), exact products, clamp at the end.
        function t_rot_out rotate(t_rot_in d);
            longint   w;
            longint   u[3];
            longint   v[3];
            longint   c[3];
            longint   t[3];
            longint   r[3];
            logic     clip;
            t_rot_out o;
            w    = longint'(d.quat_w);
            u[0] = longint'(d.quat_x);
            u[1] = longint'(d.quat_y);
            u[2] = longint'(d.quat_z);
            v[0] = longint'(d.vec_x);
            v[1] = longint'(d.vec_y);
            v[2] = longint'(d.vec_z);
            clip = 1'b0;
            // u x v carries 31 fraction bits; keep 16.
            c[0] = round_half_up(u[1] * v[2] - u[2] * v[1], 15);
            c[1] = round_half_up(u[2] * v[0] - u[0] * v[2], 15);
            c[2] = round_half_up(u[0] * v[1] - u[1] * v[0], 15);
            t[0] = w * c[0] + (u[1] * c[2] - u[2] * c[1]);
            t[1] = w * c[1] + (u[2] * c[0] - u[0] * c[2]);
            t[2] = w * c[2] + (u[0] * c[1] - u[1] * c[0]);
            for (int i = 0; i < 3; i++) begin
                // shift by 14 rather than 15 folds in the factor of two
                r[i] = v[i] + round_half_up(t[i], 14);
                if (r[i] > longint'(V_MAX)) begin
                    r[i] = longint'(V_MAX);
                    clip = 1'b1;
                end else if (r[i] < longint'(V_MIN)) begin
                    r[i] = longint'(V_MIN);
                    clip = 1'b1;
                end
            end
            o.rot_x   = r[0][31:0];
            o.rot_y   = r[1][31:0];
            o.rot_z   = r[2][31:0];
            o.clipped = clip;
            return o;
        endfunction

        function void note_input(t_rot_in d);
            rotated_q.push_back(rotate(d));
        endfunction

        function void flag(string what, longint exp_val, longint act_val);
            errors++;
            if (reports < REPORT_LIMIT)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_val, act_val);
            else if (reports == REPORT_LIMIT)
                $display("%0t ns: further mismatch reports suppressed", $time);
            reports++;
        endfunction

        function void check_output(t_rot_out got);
            t_rot_out want;
            if (rotated_q.size() == 0) begin
                errors++;
                if (reports < REPORT_LIMIT)
                    $display("%0t ns: unexpected output beat, expected none, got %h",
                             $time, got);
                reports++;
                return;
            end
            want = rotated_q.pop_front();
            if (got.rot_x !== want.rot_x)
                flag("rot_x", longint'(want.rot_x), longint'(got.rot_x));
            if (got.rot_y !== want.rot_y)
                flag("rot_y", longint'(want.rot_y), longint'(got.rot_y));
            if (got.rot_z !== want.rot_z)
                flag("rot_z", longint'(want.rot_z), longint'(got.rot_z));
            if (got.clipped !== want.clipped)
                flag("clipped", longint'(want.clipped), longint'(got.clipped));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_rot_in   in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_rot_out  out_data;

    int        cycles    = 0;
    rx_mode_e  rx_mode   = RX_OPEN;
    int        rx_left   = 0;

    rotate_scoreboard sb = new;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    quaternion_vector_rotate dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. An input beat
    // cannot produce an output in the same cycle, so call order is free.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_output(out_data);
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes to a random mode after a random hold.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     out_ready <= 1'b1;
            RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: out_ready <= ((cycles % 9) < 4);
            default:     out_ready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Sender tasks. Called at a falling edge; return at a falling edge.
    // ------------------------------------------------------------------
    task automatic push_vertex(input t_rot_in d);
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // n must be at least 1: a zero-length gap would lower and raise valid
    // in the same step.
    task automatic hold_off(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic t_rot_in make_vertex(
        input logic signed [15:0] w, x, y, z,
        input logic signed [31:0] vx, vy, vz
    );
        t_rot_in d;
        d.quat_w = w;
        d.quat_x = x;
        d.quat_y = y;
        d.quat_z = z;
        d.vec_x  = vx;
        d.vec_y  = vy;
        d.vec_z  = vz;
        return d;
    endfunction

    // Quaternion component from the extreme set {-1.0, -lsb, 0, +lsb, max}.
    function automatic logic signed [15:0] edge_quat();
        case ($urandom_range(0, 4))
            0:       return Q_NEG1;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic logic signed [31:0] edge_vec();
        case ($urandom_range(0, 5))
            0:       return V_MIN;
            1:       return -32'sd1;
            2:       return 32'sd0;
            3:       return 32'sd1;
            4:       return V_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Vector near the positive or negative limit, so rotation tends to clip.
    function automatic logic signed [31:0] near_limit_vec();
        if ($urandom_range(0, 1))
            return V_MAX - $urandom_range(0, 1 << 26);
        else
            return V_MIN + $urandom_range(0, 1 << 26);
    endfunction

    // Q16.16 value within +/-16.0
    function automatic logic signed [31:0] modest_vec();
        return $urandom_range(0, 1 << 21) - (1 << 20);
    endfunction

    // Random item. Most beats use a near-unit quaternion (a real rotation);
    // the rest cover raw bit patterns and the corners.
    function automatic t_rot_in random_vertex();
        real     a, b, c, e, n;
        int      kind;
        t_rot_in d;
        kind = $urandom_range(0, 9);
        a = $itor($urandom_range(0, 65535)) / 32767.5 - 1.0;
        b = $itor($urandom_range(0, 65535)) / 32767.5 - 1.0;
        c = $itor($urandom_range(0, 65535)) / 32767.5 - 1.0;
        e = $itor($urandom_range(0, 65535)) / 32767.5 - 1.0;
        n = $sqrt(a * a + b * b + c * c + e * e);
        if (n < 1.0e-3) begin
            a = 1.0;
            b = 0.0;
            c = 0.0;
            e = 0.0;
            n = 1.0;
        end
        d.quat_w = 16'($rtoi(32767.0 * a / n));
        d.quat_x = 16'($rtoi(32767.0 * b / n));
        d.quat_y = 16'($rtoi(32767.0 * c / n));
        d.quat_z = 16'($rtoi(32767.0 * e / n));
        case (kind)
            0, 1, 2: begin
                d.vec_x = modest_vec();
                d.vec_y = modest_vec();
                d.vec_z = modest_vec();
            end
            3, 4: begin
                d.vec_x = $urandom;
                d.vec_y = $urandom;
                d.vec_z = $urandom;
            end
            5, 6: begin
                // raw bits everywhere, mostly non-unit quaternions
                d = {$urandom, $urandom, $urandom, $urandom, $urandom};
            end
            7: begin
                d.quat_w = edge_quat();
                d.quat_x = edge_quat();
                d.quat_y = edge_quat();
                d.quat_z = edge_quat();
                d.vec_x  = edge_vec();
                d.vec_y  = edge_vec();
                d.vec_z  = edge_vec();
            end
            default: begin
                d.vec_x = near_limit_vec();
                d.vec_y = near_limit_vec();
                d.vec_z = near_limit_vec();
            end
        endcase
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_rot_in directed_q[$];
        int      sent;
        int      burst;
        int      gap_max;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero in, zero out
        directed_q.push_back(make_vertex(0, 0, 0, 0, 0, 0, 0));
        // identity: u = 0, so v passes through exactly
        directed_q.push_back(make_vertex(Q_ONE, 0, 0, 0, V_ONE, -2 * V_ONE, 3 * V_ONE));
        directed_q.push_back(make_vertex(Q_ONE, 0, 0, 0, V_MAX, V_MIN, -32'sd1));
        // w at exactly -1.0
        directed_q.push_back(make_vertex(Q_NEG1, 0, 0, 0, V_ONE, V_ONE, V_ONE));
        // quarter turns about z, x and y
        directed_q.push_back(make_vertex(Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2, V_ONE, 0, 0));
        directed_q.push_back(make_vertex(Q_HALF_SQRT2, Q_HALF_SQRT2, 0, 0, 0, V_ONE, 0));
        directed_q.push_back(make_vertex(Q_HALF_SQRT2, 0, Q_HALF_SQRT2, 0, 0, 0, V_ONE));
        // half turns, including the -1.0 code on an axis
        directed_q.push_back(make_vertex(0, Q_ONE, 0, 0, V_ONE, V_ONE, V_ONE));
        directed_q.push_back(make_vertex(0, 0, Q_NEG1, 0, V_ONE, -V_ONE, V_ONE));
        directed_q.push_back(make_vertex(0, 0, 0, Q_NEG1, 3 * V_ONE, 5 * V_ONE, 0));
        // every component at -1.0, then at max, against the vector extremes: clips
        directed_q.push_back(make_vertex(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, V_MAX, V_MAX, V_MAX));
        directed_q.push_back(make_vertex(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, V_MIN, V_MIN, V_MIN));
        directed_q.push_back(make_vertex(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, V_MAX, V_MIN, 0));
        directed_q.push_back(make_vertex(Q_ONE, Q_ONE, Q_ONE, Q_ONE, V_MIN, V_MAX, V_MIN));
        // non-unit quaternion, modest vector: scaled rotation, no clip; then one against the extremes
        directed_q.push_back(make_vertex(Q_ONE, Q_ONE, Q_ONE, Q_ONE, V_ONE, 2 * V_ONE,
                                         3 * V_ONE));
        directed_q.push_back(make_vertex(0, Q_NEG1, Q_ONE, 0, V_MAX, V_MIN, 0));
        // single-lsb values exercise the rounding steps
        directed_q.push_back(make_vertex(16'sd1, -16'sd1, 16'sd1, -16'sd1, 32'sd1, -32'sd1,
                                         32'sd1));
        directed_q.push_back(make_vertex(16'sd12345, -16'sd321, 16'sd7, 16'sd29000, 32'sd1,
                                         32'sd3, -32'sd5));
        // alternating bit patterns, then their inverse
        directed_q.push_back(make_vertex(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                                         32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555));
        directed_q.push_back(make_vertex(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                                         32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa));
        // rotation that pushes a near-limit component over the edge
        directed_q.push_back(make_vertex(Q_HALF_SQRT2, 0, 0, Q_HALF_SQRT2, V_MAX, V_MAX, 0));

        foreach (directed_q[i]) begin
            push_vertex(directed_q[i]);
            if (i % 4 == 3)
                hold_off($urandom_range(1, 3));
        end

        // Bursts with random gaps; gap_max of zero gives long back-to-back runs.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst   = $urandom_range(1, 40);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (burst) begin
                push_vertex(random_vertex());
                sent++;
            end
            if (gap_max > 0)
                hold_off($urandom_range(1, gap_max));
        end
        in_valid <= 1'b0;

        // Drain, then wait DRAIN_CYCLES for stray beats to show up.
        while (sb.rotated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
